[hw/rtl/wsc_pkg.sv]
// ----------------------------------------------------------------------------
// Waypoint steering controller package
// Shared types, codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package wsc_pkg;

    localparam int CW = 38;

    typedef logic signed [32:0]   off_t;
    typedef logic signed [CW-1:0] cw_t;
    typedef logic [1:0]           status_t;

    localparam status_t ST_RUNNING = 2'd0;
    localparam status_t ST_ARRIVED = 2'd1;
    localparam status_t ST_FAILED  = 2'd2;

    localparam logic [7:0] CFG_TIMEOUT  = 8'd0;
    localparam logic [7:0] CFG_RADIUS   = 8'd1;
    localparam logic [7:0] CFG_THROTTLE = 8'd2;
    localparam logic [7:0] CFG_STEERLIM = 8'd3;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            5'd31: v = 32'd0;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/wsc_cordic.sv]
// ----------------------------------------------------------------------------
// Iterative CORDIC vectoring unit
// One micro-rotation per cycle; returns the 32-bit world bearing of (dx, dy).
// ----------------------------------------------------------------------------
module wsc_cordic #(
    parameter int STEPS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  wsc_pkg::off_t dx_in,
    input  wsc_pkg::off_t dy_in,
    output logic          last,
    output logic          busy,
    output logic [31:0]   angle
);
    import wsc_pkg::*;

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic          busy_reg;
    logic [IW-1:0] cnt_reg;
    cw_t           x_reg;
    cw_t           y_reg;
    logic [31:0]   z_reg;
    cw_t           xs;
    cw_t           ys;
    cw_t           x0;
    cw_t           y0;
    logic [31:0]   step_angle;

    assign x0         = cw_t'(dx_in);
    assign y0         = cw_t'(dy_in);
    assign xs         = x_reg >>> cnt_reg;
    assign ys         = y_reg >>> cnt_reg;
    assign step_angle = atan_entry(5'(cnt_reg));
    assign last       = busy_reg && (cnt_reg == IW'(STEPS - 1));
    assign busy       = busy_reg;
    assign angle      = z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (last) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            if (x0 < 0) begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= 32'h8000_0000;
            end else begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end else if (busy_reg) begin
            if (y_reg < 0) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_angle;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_angle;
            end
        end
    end

endmodule

[hw/rtl/waypoint_steer_controller.sv]
// ----------------------------------------------------------------------------
// Waypoint steering controller
// Proportional bearing steering towards a goal point, with arrival and
// timeout checks, using a shared squaring multiplier and an iterative CORDIC.
// ----------------------------------------------------------------------------
// Flow: a request is taken in S_IDLE and checked in S_CHECK; a failed one goes
// to S_FIN, others pass S_SQX, S_SQY, S_SQR and S_CMP, then S_CORD unless they
// arrived or have a zero offset. A new request is taken only back in S_IDLE;
// a waiting result does not block the next request.
// Reset: synchronous, active low; restores register defaults, clears the
// start time and drops any pending result.
module waypoint_steer_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [31:0]         cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [47:0]         s_time_us,
    input  logic signed [31:0]  s_target_x,
    input  logic signed [31:0]  s_target_y,
    input  logic signed [31:0]  s_pose_x,
    input  logic signed [31:0]  s_pose_y,
    input  logic signed [15:0]  s_pose_heading,
    input  logic                s_pose_ok,

    output logic                m_valid,
    input  logic                m_ready,
    output wsc_pkg::status_t    m_status,
    output logic [47:0]         m_cmd_time_us,
    output logic [14:0]         m_throttle,
    output logic signed [15:0]  m_steering
);
    import wsc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_SQX   = 8'b0000_0100,
        S_SQY   = 8'b0000_1000,
        S_SQR   = 8'b0001_0000,
        S_CMP   = 8'b0010_0000,
        S_CORD  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] timeout_reg;
    logic [30:0] radius_reg;
    logic [14:0] throttle_reg;
    logic [14:0] steer_lim_reg;
    logic [47:0] start_reg;

    logic [47:0]        t_reg;
    logic signed [31:0] tx_reg, ty_reg, px_reg, py_reg;
    logic [15:0]        head_reg;
    logic               ok_reg;

    off_t        dx_reg, dy_reg;
    logic [32:0] ax, ay;
    logic        near_reg;
    logic        zero_reg;
    status_t     res_status_reg;

    logic [30:0] mul_a;
    logic [61:0] prod_reg;
    logic [62:0] acc_reg;

    logic [47:0] start_eff;
    logic [47:0] elapsed;
    logic        timed_out;
    logic        arrive;
    logic        offset_zero;
    logic        out_free;

    logic        cord_start, cord_last, cord_busy;
    logic [31:0] cord_angle;

    logic [31:0]        z_fin, z_rnd;
    logic [15:0]        err16;
    logic signed [16:0] steer2, lim17;
    logic signed [16:0] steer_cl;

    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [47:0]        m_time_reg;
    logic [14:0]        m_throttle_reg;
    logic signed [15:0] m_steer_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_cmd_time_us = m_time_reg;
    assign m_throttle    = m_throttle_reg;
    assign m_steering    = m_steer_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= 32'hFFFF_FFFF;
            radius_reg    <= 31'd65536;
            throttle_reg  <= 15'd16384;
            steer_lim_reg <= 15'd32767;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TIMEOUT:  timeout_reg   <= cfg_data;
                CFG_RADIUS:   radius_reg    <= cfg_data[30:0];
                CFG_THROTTLE: throttle_reg  <= cfg_data[14:0];
                CFG_STEERLIM: steer_lim_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign start_eff   = (start_reg == '0) ? t_reg : start_reg;
    assign elapsed     = t_reg - start_eff;
    assign timed_out   = elapsed > {16'd0, timeout_reg};
    assign ax          = (dx_reg < 0) ? 33'(-dx_reg) : 33'(dx_reg);
    assign ay          = (dy_reg < 0) ? 33'(-dy_reg) : 33'(dy_reg);
    assign arrive      = near_reg && (acc_reg < {1'b0, prod_reg});
    assign offset_zero = (dx_reg == '0) && (dy_reg == '0);
    assign out_free    = !m_valid_reg || m_ready;
    assign cord_start  = (state_reg == S_CMP) && !arrive && !offset_zero;

    always_comb begin
        unique case (state_reg)
            S_SQX:   mul_a = ax[30:0];
            S_SQY:   mul_a = ay[30:0];
            default: mul_a = radius_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_CHECK;
            S_CHECK: if (!ok_reg || timed_out) state_next = S_FIN;
                     else state_next = S_SQX;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_SQR;
            S_SQR:   state_next = S_CMP;
            S_CMP:   state_next = cord_start ? S_CORD : S_FIN;
            S_CORD:  if (cord_last) state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            start_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CHECK && ok_reg) begin
                start_reg <= start_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            t_reg    <= s_time_us;
            tx_reg   <= s_target_x;
            ty_reg   <= s_target_y;
            px_reg   <= s_pose_x;
            py_reg   <= s_pose_y;
            head_reg <= s_pose_heading;
            ok_reg   <= s_pose_ok;
        end
        prod_reg <= 62'(mul_a) * 62'(mul_a);
        unique case (state_reg)
            S_CHECK: begin
                dx_reg         <= off_t'(tx_reg) - off_t'(px_reg);
                dy_reg         <= off_t'(ty_reg) - off_t'(py_reg);
                res_status_reg <= ST_FAILED;
                zero_reg       <= 1'b0;
            end
            S_SQX: near_reg <= (ax < {2'b00, radius_reg}) && (ay < {2'b00, radius_reg});
            S_SQY: acc_reg  <= {1'b0, prod_reg};
            S_SQR: acc_reg  <= acc_reg + {1'b0, prod_reg};
            S_CMP: begin
                res_status_reg <= arrive ? ST_ARRIVED : ST_RUNNING;
                zero_reg       <= offset_zero;
            end
            default: ;
        endcase
    end

    wsc_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .dx_in   (dx_reg),
        .dy_in   (dy_reg),
        .last    (cord_last),
        .busy    (cord_busy),
        .angle   (cord_angle)
    );

    assign z_fin  = zero_reg ? 32'd0 : cord_angle;
    assign z_rnd  = z_fin + 32'h0000_8000;
    assign err16  = z_rnd[31:16] - head_reg;
    assign steer2 = {err16, 1'b0};
    assign lim17  = {2'b00, steer_lim_reg};

    always_comb begin
        priority if (steer2 > lim17) begin
            steer_cl = lim17;
        end else if (steer2 < -lim17) begin
            steer_cl = -lim17;
        end else begin
            steer_cl = steer2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && out_free) begin
            m_status_reg <= res_status_reg;
            if (res_status_reg == ST_RUNNING) begin
                m_time_reg     <= t_reg;
                m_throttle_reg <= throttle_reg;
                m_steer_reg    <= steer_cl[15:0];
            end else begin
                m_time_reg     <= '0;
                m_throttle_reg <= '0;
                m_steer_reg    <= '0;
            end
        end
    end

    a_zero_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_RUNNING) |->
            (m_cmd_time_us == '0) && (m_throttle == '0) && (m_steering == '0))
        else $error("non-running result carries a command");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_RUNNING) || (m_status == ST_ARRIVED)
                 || (m_status == ST_FAILED))
        else $error("result status out of range");

    a_cordic_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cord_busy)
        else $error("CORDIC busy while accepting requests");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finish step");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Waypoint steering controller testbench
// Drives goal requests and register writes through their handshakes, predicts
// every steering command in step with the accepted requests, and compares the
// command stream field by field. A directed table opens the run; random
// phases follow under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsc_pkg::*;

    localparam int          CORDIC_STEPS = 16;
    localparam int          PHASE_ITEMS  = 205;
    localparam int          PHASES       = 6;
    localparam int          RUN_LIMIT    = 1000000;
    localparam logic [7:0]  CFG_SPARE    = 8'd4;
    localparam logic [7:0]  CFG_LAST     = 8'hFF;
    localparam logic [47:0] START_T      = 48'h8000_0000_0001;
    localparam int          P_MAX        = 32'h7FFF_FFFF;
    localparam int          P_MIN        = 32'h8000_0000;

    localparam logic [31:0] ATAN_LUT [0:15] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef struct packed {
        logic [47:0] time_us;
        logic [31:0] target_x;
        logic [31:0] target_y;
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [15:0] heading;
        logic        pose_ok;
    } goal_req_t;

    typedef struct packed {
        status_t     status;
        logic [47:0] cmd_time_us;
        logic [14:0] throttle;
        logic [15:0] steering;
    } drive_cmd_t;

    typedef enum logic {ROW_GOAL, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        logic [7:0] idx;
        logic [31:0] data;
        goal_req_t  req;
        logic       typed;
        drive_cmd_t cmd;
    } stim_row_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    goal_req_t   cur_req = '0;
    logic        cur_typed = 1'b0;
    drive_cmd_t  cur_typed_cmd = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    status_t     m_status;
    logic [47:0] m_cmd_time_us;
    logic [14:0] m_throttle;
    logic signed [15:0] m_steering;

    logic [31:0] tmo_limit    = 32'hFFFF_FFFF;
    logic [30:0] arrive_rad   = 31'd65536;
    logic [14:0] throttle_cfg = 15'd16384;
    logic [14:0] steer_lim    = 15'd32767;
    logic [47:0] run_start    = '0;

    drive_cmd_t  pending_cmds[$];
    stim_row_t   dir_rows[$];
    drive_cmd_t  want;
    int          errors = 0;
    int          cycle_count = 0;
    int          send_pct = 0;
    int          rx_pct = 0;
    bit          calm = 1'b0;

    waypoint_steer_controller #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_time_us(cur_req.time_us),
        .s_target_x(cur_req.target_x),
        .s_target_y(cur_req.target_y),
        .s_pose_x(cur_req.pose_x),
        .s_pose_y(cur_req.pose_y),
        .s_pose_heading(cur_req.heading),
        .s_pose_ok(cur_req.pose_ok),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_cmd_time_us(m_cmd_time_us),
        .m_throttle(m_throttle),
        .m_steering(m_steering)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] bearing_angle(input longint x, input longint y);
        longint xs, ys;
        logic [31:0] z;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_LUT[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_LUT[i];
            end
        end
        return z;
    endfunction

    function automatic drive_cmd_t predict_cmd(input goal_req_t r);
        drive_cmd_t c;
        logic [47:0] elapsed;
        longint dx, dy, ax, ay, rad, steer, lim;
        logic [31:0] z;
        logic [15:0] b16;
        logic signed [15:0] err;
        c = '0;
        c.status = ST_FAILED;
        if (!r.pose_ok) return c;
        if (run_start == '0) run_start = r.time_us;
        elapsed = r.time_us - run_start;
        if (elapsed > {16'd0, tmo_limit}) return c;
        dx = longint'($signed(r.target_x)) - longint'($signed(r.pose_x));
        dy = longint'($signed(r.target_y)) - longint'($signed(r.pose_y));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        rad = longint'(arrive_rad);
        if (ax < rad && ay < rad && ax * ax + ay * ay < rad * rad) begin
            c.status = ST_ARRIVED;
            return c;
        end
        z = (dx == 0 && dy == 0) ? 32'd0 : bearing_angle(dx, dy);
        z = z + 32'h0000_8000;
        b16 = z[31:16];
        err = b16 - r.heading;
        steer = 2 * longint'(err);
        lim = longint'(steer_lim);
        if (steer > lim) steer = lim;
        if (steer < -lim) steer = -lim;
        c.status = ST_RUNNING;
        c.cmd_time_us = r.time_us;
        c.throttle = throttle_cfg;
        c.steering = steer[15:0];
        return c;
    endfunction

    function automatic void add_goal(input logic [47:0] t, input int tx, input int ty,
                                     input int px, input int py, input int hd,
                                     input bit ok, input bit typed = 1'b0,
                                     input status_t st = ST_RUNNING,
                                     input logic [47:0] ct = '0,
                                     input logic [14:0] th = '0,
                                     input logic [15:0] sr = '0);
        stim_row_t row;
        row = '0;
        row.kind = ROW_GOAL;
        row.req = '{time_us: t, target_x: tx, target_y: ty, pose_x: px, pose_y: py,
                    heading: hd[15:0], pose_ok: ok};
        row.typed = typed;
        row.cmd = '{status: st, cmd_time_us: ct, throttle: th, steering: sr};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [7:0] idx, input logic [31:0] data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.idx = idx;
        row.data = data;
        dir_rows.push_back(row);
    endfunction

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic send_goal(input goal_req_t r, input logic typed, input drive_cmd_t c,
                             input int idle_pct);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        cur_req <= r;
        cur_typed <= typed;
        cur_typed_cmd <= c;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_cmds();
        s_valid <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (pending_cmds.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMEOUT:  tmo_limit    = cfg_data;
                CFG_RADIUS:   arrive_rad   = cfg_data[30:0];
                CFG_THROTTLE: throttle_cfg = cfg_data[14:0];
                CFG_STEERLIM: steer_lim    = cfg_data[14:0];
                default: ;
            endcase
        end
        if (aresetn && s_valid && s_ready) begin
            want = predict_cmd(cur_req);
            pending_cmds.push_back(cur_typed ? cur_typed_cmd : want);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected command: status %0d steering %0d", m_status, m_steering);
                errors++;
            end else begin
                drive_cmd_t exp_cmd;
                exp_cmd = pending_cmds.pop_front();
                if (m_status !== exp_cmd.status) begin
                    $error("status: expected %0d, got %0d", exp_cmd.status, m_status);
                    errors++;
                end
                if (m_cmd_time_us !== exp_cmd.cmd_time_us) begin
                    $error("cmd_time_us: expected %0h, got %0h",
                           exp_cmd.cmd_time_us, m_cmd_time_us);
                    errors++;
                end
                if (m_throttle !== exp_cmd.throttle) begin
                    $error("throttle: expected %0d, got %0d", exp_cmd.throttle, m_throttle);
                    errors++;
                end
                if (m_steering !== exp_cmd.steering) begin
                    $error("steering: expected %0d, got %0d",
                           $signed(exp_cmd.steering), m_steering);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= (calm || rx_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        goal_req_t   r;
        drive_cmd_t  none;
        longint      dx, dy, span;
        logic [63:0] pick;
        logic [47:0] elapsed;
        logic [31:0] ang;
        logic [31:0] v_tmo, v_rad, v_thr, v_str;
        int          mode;

        none = '0;

        // invalid pose at the field extremes
        add_goal('1, P_MIN, P_MIN, P_MAX, P_MAX, -32768, 1'b0, 1'b1, ST_FAILED);
        // zero timestamp leaves the start time unset
        add_goal('0, 1 << 20, 0, 0, 0, 0, 1'b1);
        add_goal(START_T, 123456, -654321, 123456, -654321, 0, 1'b1, 1'b1, ST_ARRIVED);
        add_goal(START_T + 5, P_MAX, P_MAX, P_MIN, P_MIN, 32767, 1'b1);
        add_goal(START_T + 6, P_MIN, P_MIN, P_MAX, P_MAX, -32768, 1'b1);
        add_goal(START_T + 7, P_MIN, P_MAX, P_MAX, P_MIN, 0, 1'b1);
        add_goal(START_T + 8, 0, P_MIN, 0, 0, 16384, 1'b1);
        add_goal(START_T + 9, 65536, 0, 0, 0, 0, 1'b1);
        add_goal(START_T + 10, 65535, 0, 0, 0, 0, 1'b1, 1'b1, ST_ARRIVED);
        add_goal(START_T + 11, 46341, 46341, 0, 0, 0, 1'b1);
        add_goal(START_T + 12, 46340, 46340, 0, 0, 0, 1'b1, 1'b1, ST_ARRIVED);
        // elapsed time wraps below the start
        add_goal(START_T - 1, 1 << 20, 0, 0, 0, 0, 1'b1, 1'b1, ST_FAILED);
        add_goal(START_T + 48'hFFFF_FFFF, 1 << 20, 1 << 18, 0, 0, 12345, 1'b1);
        add_goal(START_T + 48'h1_0000_0000, 1 << 20, 0, 0, 0, 0, 1'b1, 1'b1, ST_FAILED);
        add_goal('0, 0, 0, 0, 0, 0, 1'b0, 1'b1, ST_FAILED);
        add_goal(START_T + 13, 1 << 20, 0, 0, 0, 16384, 1'b1);
        add_goal(START_T + 14, 1 << 20, 0, 0, 0, -16384, 1'b1);
        add_reg(CFG_STEERLIM, 32'd0);
        add_reg(CFG_RADIUS, 32'd0);
        add_reg(CFG_THROTTLE, 32'hFFFF_FFFF);
        add_reg(CFG_TIMEOUT, 32'd0);
        add_reg(CFG_SPARE, 32'hDEAD_BEEF);
        // zero offset with zero radius
        add_goal(START_T, P_MIN, P_MAX, P_MIN, P_MAX, 777, 1'b1, 1'b1, ST_RUNNING,
                 START_T, 15'h7FFF, 16'd0);
        add_goal(START_T + 1, 1 << 20, 0, 0, 0, 0, 1'b1, 1'b1, ST_FAILED);
        add_goal(START_T, -5, 3, 0, 0, 0, 1'b1, 1'b1, ST_RUNNING, START_T, 15'h7FFF, 16'd0);
        add_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        add_reg(CFG_RADIUS, 32'hFFFF_FFFF);
        add_reg(CFG_THROTTLE, 32'd0);
        add_reg(CFG_STEERLIM, 32'd12345);
        add_goal(START_T + 100, P_MAX, 0, 0, 0, 0, 1'b1);
        add_goal(START_T + 101, 1 << 30, 1 << 30, 0, 0, 0, 1'b1, 1'b1, ST_ARRIVED);
        add_goal(48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, 32767, 1'b0, 1'b1, ST_FAILED);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int n = 0; n < dir_rows.size(); n++) begin
            if (dir_rows[n].kind == ROW_REG) begin
                if (n > 0 && dir_rows[n - 1].kind == ROW_GOAL) drain_cmds();
                write_reg(dir_rows[n].idx, dir_rows[n].data);
            end else begin
                cfg_valid <= 1'b0;
                send_goal(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].cmd, 0);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_cmds();
            case (p)
                0: begin
                    v_tmo = 32'hFFFF_FFFF; v_rad = 32'd65536;
                    v_thr = 32'd16384;     v_str = 32'd32767;
                end
                1: begin
                    v_tmo = $urandom_range(1000, 100000000); v_rad = 32'd1 << 20;
                    v_thr = $urandom;                       v_str = $urandom;
                end
                2: begin
                    v_tmo = 32'd1000;  v_rad = 32'd0;
                    v_thr = 32'h7FFF;  v_str = 32'h7FFF;
                end
                3: begin
                    v_tmo = 32'hFFFF_FFFF; v_rad = 32'hFFFF_FFFF;
                    v_thr = 32'd0;         v_str = 32'd0;
                end
                4: begin
                    v_tmo = $urandom;                 v_rad = $urandom_range(0, 1 << 24);
                    v_thr = $urandom_range(0, 32767); v_str = $urandom_range(0, 32767);
                end
                default: begin
                    v_tmo = 32'd0; v_rad = 32'd4096;
                    v_thr = 32'd1; v_str = 32'd1;
                end
            endcase
            write_reg(CFG_TIMEOUT, v_tmo);
            write_reg(CFG_RADIUS, v_rad);
            write_reg(CFG_THROTTLE, v_thr);
            write_reg(CFG_STEERLIM, v_str);
            write_reg((p % 2 == 0) ? CFG_SPARE : CFG_LAST, $urandom);
            cfg_valid <= 1'b0;

            mode = p % 4;
            send_pct = (mode == 1) ? 57 : (mode == 3) ? 36 : 0;
            rx_pct   = (mode == 2) ? 57 : (mode == 3) ? 36 : 0;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 32 == 0) calm = ($urandom_range(3) == 0);

                r.pose_ok = ($urandom_range(11) != 0);
                case ($urandom_range(9))
                    0: elapsed = {16'd0, tmo_limit};
                    1: elapsed = {16'd0, tmo_limit} + 48'd1;
                    2: elapsed = 48'({$urandom, $urandom});
                    default: elapsed = {$urandom} % ({16'd0, tmo_limit} + 48'd1);
                endcase
                r.time_us = run_start + elapsed;

                if ($urandom_range(1)) begin
                    r.pose_x = $urandom;
                    r.pose_y = $urandom;
                end else begin
                    r.pose_x = $signed($urandom) >>> 12;
                    r.pose_y = $signed($urandom) >>> 12;
                end

                case ($urandom_range(3))
                    0: begin
                        dx = longint'($signed($urandom));
                        dy = longint'($signed($urandom));
                    end
                    1: begin
                        // straddle the arrival circle
                        span = 2 * longint'(arrive_rad) + 1;
                        pick = {$urandom, $urandom} % 64'(2 * span + 1);
                        dx = longint'(pick) - span;
                        pick = {$urandom, $urandom} % 64'(2 * span + 1);
                        dy = longint'(pick) - span;
                    end
                    2: begin
                        dx = longint'($signed($urandom)) >>> $urandom_range(0, 31);
                        dy = longint'($signed($urandom)) >>> $urandom_range(0, 31);
                    end
                    default: begin
                        dx = longint'($signed($urandom)) >>> $urandom_range(0, 31);
                        dy = 0;
                        if ($urandom_range(1)) begin
                            dy = dx;
                            dx = 0;
                        end
                    end
                endcase
                r.target_x = r.pose_x + dx[31:0];
                r.target_y = r.pose_y + dy[31:0];

                // hold the heading near the bearing half the time to stay off the clamp
                if ($urandom_range(1)) begin
                    r.heading = 16'($urandom);
                end else begin
                    dx = longint'($signed(r.target_x)) - longint'($signed(r.pose_x));
                    dy = longint'($signed(r.target_y)) - longint'($signed(r.pose_y));
                    ang = bearing_angle(dx, dy) + 32'h0000_8000;
                    r.heading = ang[31:16] + 16'($urandom_range(0, 8191)) - 16'd4096;
                end

                send_goal(r, 1'b0, none, calm ? 0 : send_pct);
            end
        end

        drain_cmds();
        repeat (CORDIC_STEPS + 8) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
